>>> design/icc_pkg.sv
// Package for the interval containment counter.
// Holds payload structs, cell data structs, control struct and state codes.
// No dependencies.
`default_nettype none

package icc_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int VAL_W          = 32;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 6;

  typedef struct packed {
    logic [VAL_W-1:0] range_start;
    logic [VAL_W-1:0] range_end;
    logic             final_range;
  } range_t;

  typedef struct packed {
    logic [IDX_W-1:0] range_index;
    logic [CNT_W-1:0] contains_count;
    logic [CNT_W-1:0] contained_count;
    logic             overflow_flag;
    logic             last_result;
  } result_t;

  // Stored range of a cell with its two tallies
  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic             valid;
    logic [CNT_W-1:0] inner;
    logic [CNT_W-1:0] outer;
  } slot_t;

  // Range travelling round the ring
  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic             valid;
  } probe_t;

  typedef struct packed {
    logic shift;   // take slot from the previous cell
    logic fill;    // head of the chain takes a new range
    logic rotate;  // advance probes round the ring
    logic tally;   // compare own range against probe
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COMPARE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> design/icc_cell.sv
// One cell of the containment chain: a stored range, a probe and two tallies.
// Depends on icc_pkg.
`default_nettype none

module icc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire icc_pkg::cell_ctl_t ctl,
  input  wire icc_pkg::slot_t    prev_slot,
  input  wire icc_pkg::probe_t   prev_probe,
  output icc_pkg::slot_t         slot,
  output icc_pkg::probe_t        probe
);

  localparam logic [icc_pkg::CNT_W-1:0] CNT_ONE = icc_pkg::CNT_W'(1);

  logic hit_inner;
  logic hit_outer;

  assign hit_inner = (probe.lo >= slot.lo) && (probe.hi <= slot.hi);
  assign hit_outer = (probe.lo <= slot.lo) && (probe.hi >= slot.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid  <= 1'b0;
      probe.valid <= 1'b0;
    end else if (ctl.shift) begin
      slot.valid  <= prev_slot.valid;
      probe.valid <= prev_slot.valid;
    end else if (ctl.rotate) begin
      probe.valid <= prev_probe.valid;
    end

    if (ctl.shift) begin
      slot.lo    <= prev_slot.lo;
      slot.hi    <= prev_slot.hi;
      slot.inner <= prev_slot.inner;
      slot.outer <= prev_slot.outer;
      probe.lo   <= prev_slot.lo;
      probe.hi   <= prev_slot.hi;
    end else begin
      if (ctl.tally && slot.valid && probe.valid) begin
        if (hit_inner) slot.inner <= slot.inner + CNT_ONE;
        if (hit_outer) slot.outer <= slot.outer + CNT_ONE;
      end
      if (ctl.rotate) begin
        probe.lo <= prev_probe.lo;
        probe.hi <= prev_probe.hi;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/icc_ctrl.sv
// Sequencer for the containment chain: load, ring compare and emission.
// Keeps the load count, drop mark and result index. Depends on icc_pkg.
`default_nettype none

module icc_ctrl #(
  parameter int MAX_RANGES = icc_pkg::MAX_RANGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               in_final,
  input  wire logic               top_valid,
  input  wire logic               out_free,
  output icc_pkg::cell_ctl_t      ctl,
  output logic                    in_ready,
  output logic                    take,
  output logic [icc_pkg::IDX_W-1:0] index,
  output logic                    last,
  output logic                    overflow
);

  localparam int CW     = $clog2(MAX_RANGES + 1);
  localparam int STEP_W = $clog2(MAX_RANGES);
  localparam int WIDE   = icc_pkg::IDX_W + 1;

  icc_pkg::state_t     state, state_next;
  logic [CW-1:0]       loaded_count, loaded_count_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [icc_pkg::IDX_W-1:0] index_next;
  logic                overflow_next;
  logic                room;
  logic                step_end;

  assign room     = loaded_count < CW'(MAX_RANGES);
  assign step_end = step == STEP_W'(MAX_RANGES - 1);
  assign last     = (WIDE'(index) + WIDE'(1)) == WIDE'(loaded_count);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      icc_pkg::ST_LOAD: begin
        if (in_fire && in_final) state_next = icc_pkg::ST_COMPARE;
      end
      icc_pkg::ST_COMPARE: begin
        if (step_end) state_next = icc_pkg::ST_EMIT;
      end
      icc_pkg::ST_EMIT: begin
        if (take && last) state_next = icc_pkg::ST_LOAD;
      end
      default: state_next = icc_pkg::ST_LOAD;
    endcase
  end

  // Outputs to the chain and handshake
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    take     = 1'b0;
    case (state)
      icc_pkg::ST_LOAD: begin
        in_ready  = 1'b1;
        ctl.fill  = 1'b1;
        ctl.shift = in_fire && room;
      end
      icc_pkg::ST_COMPARE: begin
        ctl.rotate = 1'b1;
        ctl.tally  = step != '0;
      end
      icc_pkg::ST_EMIT: begin
        ctl.shift = out_free || !top_valid;
        take      = out_free && top_valid;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Counters and marks
  always_comb begin
    loaded_count_next = loaded_count;
    overflow_next     = overflow;
    step_next         = step;
    index_next        = index;
    case (state)
      icc_pkg::ST_LOAD: begin
        step_next  = '0;
        index_next = '0;
        if (in_fire) begin
          if (room) loaded_count_next = loaded_count + CW'(1);
          else      overflow_next     = 1'b1;
        end
      end
      icc_pkg::ST_COMPARE: begin
        step_next = step + STEP_W'(1);
      end
      icc_pkg::ST_EMIT: begin
        if (take) begin
          index_next = index + icc_pkg::IDX_W'(1);
          if (last) begin
            loaded_count_next = '0;
            overflow_next     = 1'b0;
          end
        end
      end
      default: begin
        step_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= icc_pkg::ST_LOAD;
      loaded_count <= '0;
      overflow     <= 1'b0;
      step         <= '0;
      index        <= '0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      overflow     <= overflow_next;
      step         <= step_next;
      index        <= index_next;
    end
  end

endmodule

`default_nettype wire

>>> design/interval_containment_counter.sv
// Interval containment counter: ranges load into a chain of cells.
// After the final transaction the probes rotate round the ring for the comparison,
// then the chain shifts the results out of the top cell, oldest first.
// Throughput: one range per cycle while loading; one result per cycle while emitting,
// when the receiver is ready. The block takes no new set until the last result is out.
// Reset (rst, synchronous, active high) empties the chain and returns to loading.
`default_nettype none

module interval_containment_counter #(
  parameter int MAX_RANGES = icc_pkg::MAX_RANGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             range_valid,
  output logic                  range_ready,
  input  wire icc_pkg::range_t  range_data,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output icc_pkg::result_t      result_data
);

  icc_pkg::cell_ctl_t ctl;
  icc_pkg::slot_t     slots  [MAX_RANGES];
  icc_pkg::probe_t    probes [MAX_RANGES];
  icc_pkg::slot_t     head;
  icc_pkg::slot_t     top;

  logic                      in_fire;
  logic                      out_free;
  logic                      take;
  logic                      last;
  logic                      overflow;
  logic [icc_pkg::IDX_W-1:0] index;

  assign in_fire  = range_valid && range_ready;
  // The output register is free when empty or being drained this cycle
  assign out_free = !result_valid || result_ready;
  assign top      = slots[MAX_RANGES-1];

  // Head of the chain: a new range while loading, empty slots while emitting
  always_comb begin
    head.lo    = range_data.range_start;
    head.hi    = range_data.range_end;
    head.valid = ctl.fill;
    head.inner = '0;
    head.outer = '0;
  end

  icc_ctrl #(
    .MAX_RANGES (MAX_RANGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_final  (range_data.final_range),
    .top_valid (top.valid),
    .out_free  (out_free),
    .ctl       (ctl),
    .in_ready  (range_ready),
    .take      (take),
    .index     (index),
    .last      (last),
    .overflow  (overflow)
  );

  // Newest range sits in cell 0; the oldest drifts towards the top cell, so
  // emission from the top comes out in load order. Probes rotate as a ring:
  // over MAX_RANGES steps every cell meets every other stored range once,
  // and the first step (its own copy) is left out of the tallies.
  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    icc_pkg::slot_t  prev_slot;
    icc_pkg::probe_t prev_probe;

    if (k == 0) begin : g_first
      assign prev_slot  = head;
      assign prev_probe = probes[MAX_RANGES-1];
    end else begin : g_rest
      assign prev_slot  = slots[k-1];
      assign prev_probe = probes[k-1];
    end

    icc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_slot  (prev_slot),
      .prev_probe (prev_probe),
      .slot       (slots[k]),
      .probe      (probes[k])
    );
  end

  // Output register: hold a result until taken, refill from the top cell
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_data.range_index     <= index;
      result_data.contains_count  <= top.inner;
      result_data.contained_count <= top.outer;
      result_data.overflow_flag   <= overflow;
      result_data.last_result     <= last;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for interval_containment_counter: predicts the containment
// tallies of every loaded set and compares each result transaction field by field.
// Depends on icc_pkg and the interval_containment_counter RTL.

module testbench;

  localparam int RANGE_CAP  = icc_pkg::MAX_RANGES_DEF;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_CYC = 2 * RANGE_CAP + 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             range_valid = 1'b0;
  logic             range_ready;
  icc_pkg::range_t  range_data = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  icc_pkg::result_t result_data;

  // Predictor state: ranges of the set being loaded, and the tallies still owed
  logic [icc_pkg::VAL_W-1:0] held_lo[$];
  logic [icc_pkg::VAL_W-1:0] held_hi[$];
  bit                        held_dropped;
  icc_pkg::result_t          awaited_tallies[$];

  int mismatches;
  bit sender_jitter;
  bit receiver_jitter;
  int long_hold_cycles;

  always #4 clk = ~clk;

  interval_containment_counter #(
    .MAX_RANGES(RANGE_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .range_valid(range_valid),
    .range_ready(range_ready),
    .range_data(range_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data(result_data)
  );

  // Absorb one accepted range; on the final one work out a tally per stored range,
  // in load order, then empty the set.
  task automatic tally_containment(input icc_pkg::range_t item);
    icc_pkg::result_t tally;
    int               inner;
    int               outer;
    int               n;
    if (held_lo.size() < RANGE_CAP) begin
      held_lo.push_back(item.range_start);
      held_hi.push_back(item.range_end);
    end else begin
      held_dropped = 1'b1;
    end
    if (!item.final_range) return;
    n = held_lo.size();
    for (int i = 0; i < n; i++) begin
      inner = 0;
      outer = 0;
      for (int j = 0; j < n; j++) begin
        if (j != i) begin
          // Identical ranges land in both tallies of each other
          if (held_lo[j] >= held_lo[i] && held_hi[j] <= held_hi[i]) inner++;
          if (held_lo[j] <= held_lo[i] && held_hi[j] >= held_hi[i]) outer++;
        end
      end
      tally.range_index     = i[icc_pkg::IDX_W-1:0];
      tally.contains_count  = inner[icc_pkg::CNT_W-1:0];
      tally.contained_count = outer[icc_pkg::CNT_W-1:0];
      tally.overflow_flag   = held_dropped;
      tally.last_result     = (i == n - 1);
      awaited_tallies.push_back(tally);
    end
    held_lo.delete();
    held_hi.delete();
    held_dropped = 1'b0;
  endtask

  // Offer one range and hold it until the block takes it. Valid is only lowered
  // when a gap follows, so it never drops and rises within one time step.
  task automatic offer_range(input logic [icc_pkg::VAL_W-1:0] lo,
                             input logic [icc_pkg::VAL_W-1:0] hi,
                             input logic fin);
    int              gap;
    int              roll;
    icc_pkg::range_t item;
    gap = 0;
    if (sender_jitter) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(6, 30);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      range_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.range_start = lo;
    item.range_end   = hi;
    item.final_range = fin;
    range_valid <= 1'b1;
    range_data  <= item;
    do @(posedge clk); while (!range_ready);
    tally_containment(item);
  endtask

  // Hold the sender off until every owed tally has come back
  task automatic await_drain();
    range_valid <= 1'b0;
    do @(posedge clk); while (awaited_tallies.size() != 0);
  endtask

  // Mostly clustered, well-ordered bounds near a base; some fully random, some reversed
  function automatic logic [2*icc_pkg::VAL_W-1:0] draw_bounds(
      input logic [icc_pkg::VAL_W-1:0] base);
    logic [icc_pkg::VAL_W-1:0] a;
    logic [icc_pkg::VAL_W-1:0] b;
    int                        roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      a = $urandom;
      b = $urandom;
    end else begin
      a = base + $urandom_range(0, 12);
      b = base + $urandom_range(0, 12);
    end
    if (roll < 90 && a > b) return {b, a};
    return {a, b};
  endfunction

  function automatic logic [icc_pkg::VAL_W-1:0] draw_base();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll < 2) return '0;
    if (roll == 2) return $urandom;
    return 32'hFFFF_FFF0;
  endfunction

  // Single-range sets at the extremes of both endpoints
  task automatic test_lone_range();
    offer_range(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    offer_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer_range(32'h0000_0000, 32'h0000_0000, 1'b1);
    offer_range(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    await_drain();
  endtask

  // Nesting, identical ranges, points and reversed ranges in one set
  task automatic test_nesting_cases();
    offer_range(32'd10, 32'd20, 1'b0);
    offer_range(32'd12, 32'd18, 1'b0);
    offer_range(32'd12, 32'd18, 1'b0);
    offer_range(32'd10, 32'd20, 1'b0);
    offer_range(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    offer_range(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    offer_range(32'd15, 32'd15, 1'b0);
    offer_range(32'd20, 32'd10, 1'b0);
    offer_range(32'd12, 32'd20, 1'b1);
    await_drain();
  endtask

  // Fill the block exactly, without idling on either side, then overrun it so
  // that two plain loads and the closing one are all dropped.
  task automatic test_capacity_overflow();
    logic [icc_pkg::VAL_W-1:0]   base;
    logic [2*icc_pkg::VAL_W-1:0] bounds;
    sender_jitter   = 1'b0;
    receiver_jitter = 1'b0;
    base = draw_base();
    for (int k = 0; k < RANGE_CAP; k++) begin
      bounds = draw_bounds(base);
      offer_range(bounds[2*icc_pkg::VAL_W-1:icc_pkg::VAL_W], bounds[icc_pkg::VAL_W-1:0],
                  k == RANGE_CAP - 1);
    end
    await_drain();
    sender_jitter   = 1'b1;
    receiver_jitter = 1'b1;
    base = draw_base();
    for (int k = 0; k < RANGE_CAP + 3; k++) begin
      bounds = draw_bounds(base);
      offer_range(bounds[2*icc_pkg::VAL_W-1:icc_pkg::VAL_W], bounds[icc_pkg::VAL_W-1:0],
                  k == RANGE_CAP + 2);
    end
    await_drain();
  endtask

  // Random sets, mostly small, with clustered contents so that tallies are non-trivial
  task automatic test_random_sets();
    int                          loaded;
    int                          set_len;
    logic [icc_pkg::VAL_W-1:0]   base;
    logic [2*icc_pkg::VAL_W-1:0] bounds;
    loaded = 0;
    while (loaded < 8) begin
      set_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      base = draw_base();
      for (int k = 0; k < set_len; k++) begin
        bounds = draw_bounds(base);
        offer_range(bounds[2*icc_pkg::VAL_W-1:icc_pkg::VAL_W], bounds[icc_pkg::VAL_W-1:0],
                    k == set_len - 1);
      end
      loaded += set_len;
      if ($urandom_range(0, 9) == 0) await_drain();
    end
    await_drain();
  endtask

  // Hold the receiver off for a long stretch while two sets are offered back to
  // back, so results back up and the second set stalls at the input.
  task automatic test_receiver_backpressure();
    logic [icc_pkg::VAL_W-1:0]   base;
    logic [2*icc_pkg::VAL_W-1:0] bounds;
    long_hold_cycles = LONG_HOLD;
    for (int s = 0; s < 2; s++) begin
      base = draw_base();
      for (int k = 0; k < 6; k++) begin
        bounds = draw_bounds(base);
        offer_range(bounds[2*icc_pkg::VAL_W-1:icc_pkg::VAL_W], bounds[icc_pkg::VAL_W-1:0],
                    k == 5);
      end
    end
    await_drain();
  endtask

  task automatic compare_tally_field(input string field, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Check every result transaction against the oldest owed tally
  always @(posedge clk) begin : tally_checker
    icc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_tallies.size() == 0) begin
        mismatches++;
        $error("unexpected result transaction, range_index %0d", result_data.range_index);
      end else begin
        want = awaited_tallies.pop_front();
        compare_tally_field("range_index", 8'(want.range_index),
                            8'(result_data.range_index));
        compare_tally_field("contains_count", 8'(want.contains_count),
                            8'(result_data.contains_count));
        compare_tally_field("contained_count", 8'(want.contained_count),
                            8'(result_data.contained_count));
        compare_tally_field("overflow_flag", 8'(want.overflow_flag),
                            8'(result_data.overflow_flag));
        compare_tally_field("last_result", 8'(want.last_result),
                            8'(result_data.last_result));
      end
    end
  end

  // Pace the receiver: short random stalls, now and then a long one, and a
  // counted hold-off whenever a test asks for it.
  initial begin : result_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        stall_left = long_hold_cycles;
        long_hold_cycles = 0;
      end else if (stall_left == 0 && receiver_jitter && $urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : run_tests
    mismatches       = 0;
    held_dropped     = 1'b0;
    sender_jitter    = 1'b1;
    receiver_jitter  = 1'b1;
    long_hold_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_lone_range();
    test_nesting_cases();
    test_capacity_overflow();
    test_random_sets();
    test_receiver_backpressure();
    // Watch for stray results once nothing is owed any more
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("interval_containment_counter verification clean");
    end else begin
      $display("interval_containment_counter verification failed");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("interval_containment_counter verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/icc_pkg.sv
design/icc_cell.sv
design/icc_ctrl.sv
design/interval_containment_counter.sv
tb/testbench.sv
